>>> rtl/rfr_pkg.sv
// package: types, character codes and helper functions for the request frame receiver
package rfr_pkg;

	localparam logic [7:0] CharQuery = 8'h3f;
	localparam logic [7:0] CharBar = 8'h7c;
	localparam logic [7:0] CharD = 8'h44;
	localparam logic [7:0] CharP = 8'h50;
	localparam logic [7:0] CharCr = 8'h0d;
	localparam logic [7:0] CharLf = 8'h0a;

	localparam int FrameLen = 10;
	localparam int CrcEndPos = 6;
	localparam logic [15:0] CrcPoly = 16'ha001;

	localparam logic [1:0] StatusOk = 2'd0;
	localparam logic [1:0] StatusLength = 2'd1;
	localparam logic [1:0] StatusFormat = 2'd2;
	localparam logic [1:0] StatusCrc = 2'd3;

	typedef struct packed {
		logic valid;
		logic [7:0] data;
	} rx_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic request_kind;
		logic [7:0] unit_addr;
	} result_t;

	typedef struct packed {
		logic valid;
		result_t res;
	} result_word_t;

	function automatic logic [15:0] crc_arc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end
		return v;
	endfunction

endpackage

>>> rtl/rfr_if.sv
// interfaces: valid/ready channels for received bytes and for frame results
interface rfr_rx_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfr_result_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic request_kind;
	logic [7:0] unit_addr;

	modport source (output valid, output status, output request_kind, output unit_addr,
		input ready);
	modport sink (input valid, input status, input request_kind, input unit_addr,
		output ready);
endinterface

>>> rtl/request_frame_receiver.sv
// top level: request frame receiver built from input register, parser and result register
//
// rx carries one received character per transfer; result carries status,
// request_kind and unit_addr, once for each LF that closes a started frame.
// status 0 ok, 1 wrong length, 2 bad format, 3 crc mismatch; kind and addr are
// zero unless ok. Bytes outside a frame, CR and the byte after an overlong
// frame give no result.
// a byte is registered in the input stage, then the parser updates its state
// and loads the result register, from which the LF's result is offered.
// throughput: one byte per cycle while the result sink does not stall; the crc
// step is a combinational byte update and the parser state advances once per byte.
// when the result sink stalls, the held result stays put; one more byte may
// wait in the input register, after which rx.ready drops until the result
// is taken.
// reset clears the byte count, crc, captured fields and both valid flags.
module request_frame_receiver #(
	parameter int BUFFER_LIMIT = 64
) (
	input  logic clk,
	input  logic arst_n,
	rfr_rx_if.sink rx,
	rfr_result_if.source result
);
	import rfr_pkg::*;

	rx_word_t word_s1;
	result_word_t parse_res;
	result_t out_res;
	logic advance;

	rfr_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(rx.valid),
		.in_byte(rx.rx_byte),
		.in_ready(rx.ready),
		.advance(advance),
		.word_s1(word_s1)
	);

	rfr_frame_parser #(.BUFFER_LIMIT(BUFFER_LIMIT)) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.word_s1(word_s1),
		.advance(advance),
		.result(parse_res)
	);

	rfr_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.result(parse_res),
		.advance(advance),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.out_res(out_res)
	);

	assign result.status = out_res.status;
	assign result.request_kind = out_res.request_kind;
	assign result.unit_addr = out_res.unit_addr;
endmodule

>>> rtl/rfr_in_stage.sv
// input register: captures one received byte per transfer
module rfr_in_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [7:0] in_byte,
	output logic in_ready,
	input  logic advance,
	output rfr_pkg::rx_word_t word_s1
);
	import rfr_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign word_s1 = '{valid: valid_s1, data: byte_s1};
endmodule

>>> rtl/rfr_frame_parser.sv
// frame parser: byte count, running crc, captured fields and end-of-frame check
module rfr_frame_parser #(
	parameter int BUFFER_LIMIT = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  rfr_pkg::rx_word_t word_s1,
	input  logic advance,
	output rfr_pkg::result_word_t result
);
	import rfr_pkg::*;

	localparam int CountW = $clog2(BUFFER_LIMIT + 1);

	logic [CountW-1:0] count_q;
	logic [15:0] crc_q;
	logic [7:0] id_q;
	logic [7:0] kind_q;
	logic [7:0] sep_q;
	logic [15:0] rcrc_q;

	logic [CountW-1:0] count_d;
	logic [15:0] crc_d;
	logic [7:0] id_d;
	logic [7:0] kind_d;
	logic [7:0] sep_d;
	logic [15:0] rcrc_d;
	logic [15:0] crc_base;
	logic [3:0] hex;
	logic [7:0] c;
	logic step;

	assign c = word_s1.data;
	assign step = word_s1.valid && advance;
	assign hex = hex_value(c);
	assign crc_base = (count_q == '0) ? 16'h0000 : crc_q;

	always_comb begin
		count_d = count_q;
		crc_d = crc_q;
		id_d = id_q;
		kind_d = kind_q;
		sep_d = sep_q;
		rcrc_d = rcrc_q;
		result.valid = 1'b0;
		result.res = '{status: StatusOk, request_kind: 1'b0, unit_addr: 8'h00};
		if (count_q == '0 && c != CharQuery) begin
			// idle, waiting for a frame start
		end else if (count_q >= CountW'(BUFFER_LIMIT)) begin
			count_d = '0;
		end else if (c == CharCr) begin
			// dropped
		end else if (c == CharLf) begin
			result.valid = 1'b1;
			count_d = '0;
			if (count_q != CountW'(FrameLen)) begin
				result.res.status = StatusLength;
			end else if (sep_q != CharBar || (kind_q != CharD && kind_q != CharP)) begin
				result.res.status = StatusFormat;
			end else if (crc_q != rcrc_q) begin
				result.res.status = StatusCrc;
			end else begin
				result.res.request_kind = (kind_q == CharP);
				result.res.unit_addr = id_q;
			end
		end else begin
			if (count_q == '0) begin
				id_d = 8'h00;
				kind_d = 8'h00;
				sep_d = 8'h00;
				rcrc_d = 16'h0000;
			end
			crc_d = crc_base;
			if (count_q < CountW'(CrcEndPos)) begin
				crc_d = crc_arc_step(crc_base, c);
			end
			if (count_q == CountW'(1) || count_q == CountW'(2)) begin
				id_d = {id_q[3:0], hex};
			end else if (count_q == CountW'(4)) begin
				kind_d = c;
			end else if (count_q == CountW'(5)) begin
				sep_d = c;
			end else if (count_q >= CountW'(CrcEndPos) && count_q < CountW'(FrameLen)) begin
				rcrc_d = {rcrc_q[11:0], hex};
			end
			count_d = count_q + CountW'(1);
		end
		if (!step) begin
			result.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q <= 16'h0000;
			id_q <= 8'h00;
			kind_q <= 8'h00;
			sep_q <= 8'h00;
			rcrc_q <= 16'h0000;
		end else if (step) begin
			count_q <= count_d;
			crc_q <= crc_d;
			id_q <= id_d;
			kind_q <= kind_d;
			sep_q <= sep_d;
			rcrc_q <= rcrc_d;
		end
	end
endmodule

>>> rtl/rfr_out_stage.sv
// result register: holds one frame result until the sink takes it
module rfr_out_stage (
	input  logic clk,
	input  logic arst_n,
	input  rfr_pkg::result_word_t result,
	output logic advance,
	output logic out_valid,
	input  logic out_ready,
	output rfr_pkg::result_t out_res
);
	import rfr_pkg::*;

	logic valid_q;
	result_t res_q;

	assign advance = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			res_q <= result.res;
		end
	end
endmodule
